// File: src/svg_pkg.sv
`timescale 1ns / 1ps

package svg_pkg;

  // Default sizes, handed to the top level parameters
  localparam int unsigned DEF_MAX_WIDTH  = 256;
  localparam int unsigned DEF_MAX_HEIGHT = 256;
  localparam int unsigned DEF_PIXEL_BITS = 16;

  // Fixed field widths
  localparam int unsigned CFG_W      = 9;
  localparam int unsigned GRAD_W     = 20;
  localparam int unsigned COORD_W    = 8;
  localparam int unsigned VAR_W      = 50;
  localparam int unsigned ACC_W      = 32;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // Result item layout on the output tdata
  localparam int unsigned GRAD_LSB   = 0;
  localparam int unsigned ROW_LSB    = GRAD_LSB + GRAD_W;
  localparam int unsigned COL_LSB    = ROW_LSB + COORD_W;
  localparam int unsigned TOT_LSB    = COL_LSB + COORD_W;
  localparam int unsigned OUT_DATA_W = ((TOT_LSB + VAR_W + 7) / 8) * 8;

  localparam logic [CFG_W-1:0]        RESET_DIM = 9'd256;
  localparam logic [VAR_W-1:0]        VAR_MAX   = '1;
  localparam logic signed [ACC_W-1:0] GRAD_HI   = 32'sd524287;
  localparam logic signed [ACC_W-1:0] GRAD_LO   = -32'sd524288;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_e;

  // Control tag that rides along with each item through the pipeline
  typedef struct packed {
    logic               res;   // item produces a result
    logic               last;  // final gradient of the image
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } svg_tag_t;

  // Effective image dimension: zero acts as one, clamp at the maximum
  function automatic int unsigned eff_dim(logic [CFG_W-1:0] v, int unsigned maxv);
    int unsigned d;
    d = 32'(v);
    if (d == 0) begin
      d = 1;
    end else if (d > maxv) begin
      d = maxv;
    end
    return d;
  endfunction

endpackage

// File: src/svg_line_mem.sv
`timescale 1ns / 1ps

module svg_line_mem import svg_pkg::*; #(
  parameter int unsigned DEPTH  = DEF_MAX_WIDTH,
  parameter int unsigned DATA_W = 2 * DEF_PIXEL_BITS,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // write-first on a same-address collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= (we_i && (waddr_i == raddr_i)) ? wdata_i : mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/svg_ctrl.sv
`timescale 1ns / 1ps

module svg_ctrl import svg_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int unsigned PIXEL_BITS = DEF_PIXEL_BITS,
  localparam int unsigned CW = $clog2(MAX_WIDTH),
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
  localparam int unsigned DW = PIXEL_BITS + 1,
  localparam int unsigned AW = PIXEL_BITS + 3,
  localparam int unsigned EW = 2 * PIXEL_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         restart_i,
  input  logic [CW-1:0]                wlast_i,
  input  logic [RW-1:0]                hlast_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  op_e                          in_op_i,
  input  logic signed [PIXEL_BITS-1:0] in_pixel_i,
  output logic                         mem_we_o,
  output logic [CW-1:0]                mem_waddr_o,
  output logic [EW-1:0]                mem_wdata_o,
  output logic                         mem_re_o,
  output logic [CW-1:0]                mem_raddr_o,
  input  logic [EW-1:0]                mem_rdata_i,
  output logic                         s1_valid_o,
  output svg_tag_t                     s1_tag_o,
  output logic signed [DW-1:0]         s1_dl_o,
  output logic signed [DW-1:0]         s1_du_o,
  output logic signed [AW-1:0]         s1_acc_o,
  input  logic                         s2_ready_i
);

  localparam logic signed [AW-1:0] ZERO_A = '0;
  localparam logic signed [DW-1:0] ZERO_D = '0;

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          drain_q, drain_d;
  logic [EW-1:0] cen_q, cen_d;            // {above, two above} at the current column
  logic signed [PIXEL_BITS-1:0] lft_q;    // above value one column to the left
  logic signed [PIXEL_BITS-1:0] lp_q;     // previous pixel in this row

  logic                  s1_valid_q, s1_valid_d;
  svg_tag_t              s1_tag_q, s1_tag_d;
  logic signed [DW-1:0]  s1_dl_q, s1_dl_d, s1_du_q, s1_du_d;
  logic signed [AW-1:0]  s1_acc_q, s1_acc_d;

  logic accept, is_pix, is_drn, act, at_end;
  logic e_lft, e_rgt, e_top, row_nz;
  logic signed [PIXEL_BITS-1:0] ctr, top, rgt;
  logic [CW:0] ahead;

  assign in_ready_o = !s1_valid_q || s2_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_pix     = accept && (in_op_i == OP_PIXEL) && !drain_q;
  assign is_drn     = accept && (in_op_i == OP_DRAIN) && drain_q;
  assign act        = is_pix || is_drn;

  assign ctr    = cen_q[EW-1:PIXEL_BITS];
  assign top    = cen_q[PIXEL_BITS-1:0];
  assign rgt    = mem_rdata_i[EW-1:PIXEL_BITS];
  assign at_end = (col_q == wlast_i);
  assign row_nz = (row_q != '0);
  assign e_lft  = (col_q != '0);
  assign e_rgt  = !at_end;
  assign e_top  = drain_q ? (hlast_i != '0) : (row_q > RW'(1));

  // Line store access: write this column, prefetch two columns ahead (wrapping)
  always_comb begin
    ahead = {1'b0, col_q} + (CW + 1)'(2);
    if (wlast_i == '0) begin
      mem_raddr_o = '0;
    end else if (ahead > {1'b0, wlast_i}) begin
      mem_raddr_o = CW'(ahead - {1'b0, wlast_i} - (CW + 1)'(1));
    end else begin
      mem_raddr_o = CW'(ahead);
    end
  end

  assign mem_we_o    = is_pix;
  assign mem_waddr_o = col_q;
  assign mem_wdata_o = {in_pixel_i, ctr};
  assign mem_re_o    = act;

  // Stage 1 payload
  always_comb begin
    s1_acc_d = (is_pix ? AW'(ctr) - AW'(in_pixel_i) : ZERO_A)
             + (e_lft  ? AW'(ctr) - AW'(lft_q)      : ZERO_A)
             + (e_rgt  ? AW'(ctr) - AW'(rgt)        : ZERO_A)
             + (e_top  ? AW'(ctr) - AW'(top)        : ZERO_A);
    s1_dl_d = (is_pix && e_lft) ? DW'(in_pixel_i) - DW'(lp_q) : ZERO_D;
    s1_du_d = (is_pix && row_nz) ? DW'(in_pixel_i) - DW'(ctr) : ZERO_D;
    s1_tag_d.res  = is_pix ? row_nz : 1'b1;
    s1_tag_d.last = is_drn && at_end;
    s1_tag_d.row  = is_pix ? COORD_W'(row_q - RW'(1)) : COORD_W'(hlast_i);
    s1_tag_d.col  = COORD_W'(col_q);
    s1_valid_d    = act || (s1_valid_q && !s2_ready_i);
  end

  // Window: with a one-column image the column just written is the next center
  assign cen_d = act ? ((is_pix && (wlast_i == '0)) ? mem_wdata_o : mem_rdata_i) : cen_q;

  // Raster and drain position
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    drain_d = drain_q;
    if (restart_i) begin
      col_d   = '0;
      row_d   = '0;
      drain_d = 1'b0;
    end else if (is_pix) begin
      if (at_end) begin
        col_d = '0;
        if (row_q == hlast_i) begin
          drain_d = 1'b1;
        end else begin
          row_d = row_q + RW'(1);
        end
      end else begin
        col_d = col_q + CW'(1);
      end
    end else if (is_drn) begin
      if (at_end) begin
        col_d   = '0;
        row_d   = '0;
        drain_d = 1'b0;
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      drain_q    <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      drain_q    <= drain_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cen_q <= cen_d;
    if (act) begin
      lft_q    <= ctr;
      s1_tag_q <= s1_tag_d;
      s1_dl_q  <= s1_dl_d;
      s1_du_q  <= s1_du_d;
      s1_acc_q <= s1_acc_d;
    end
    if (is_pix) begin
      lp_q <= in_pixel_i;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_tag_o   = s1_tag_q;
  assign s1_dl_o    = s1_dl_q;
  assign s1_du_o    = s1_du_q;
  assign s1_acc_o   = s1_acc_q;

endmodule

// File: src/svg_accum.sv
`timescale 1ns / 1ps

module svg_accum import svg_pkg::*; #(
  parameter int unsigned PIXEL_BITS = DEF_PIXEL_BITS,
  localparam int unsigned DW   = PIXEL_BITS + 1,
  localparam int unsigned AW   = PIXEL_BITS + 3,
  localparam int unsigned SQ_W = 2 * DW,
  localparam int unsigned T_W  = VAR_W + 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 restart_i,
  input  logic                 s1_valid_i,
  input  svg_tag_t             s1_tag_i,
  input  logic signed [DW-1:0] s1_dl_i,
  input  logic signed [DW-1:0] s1_du_i,
  input  logic signed [AW-1:0] s1_acc_i,
  output logic                 s2_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [GRAD_W-1:0]    out_grad_o,
  output logic [COORD_W-1:0]   out_row_o,
  output logic [COORD_W-1:0]   out_col_o,
  output logic [VAR_W-1:0]     out_total_o,
  output logic                 out_last_o
);

  logic                 s2_valid_q, s2_valid_d;
  svg_tag_t             s2_tag_q;
  logic [SQ_W-1:0]      sql_q, squ_q;
  logic [GRAD_W-1:0]    s2_grad_q;

  logic [VAR_W-1:0]     sum_q, sum_d;
  logic                 out_valid_q, out_valid_d;
  logic [GRAD_W-1:0]    out_grad_q;
  logic [COORD_W-1:0]   out_row_q, out_col_q;
  logic [VAR_W-1:0]     out_total_q;
  logic                 out_last_q;

  logic signed [SQ_W-1:0]  prod_l, prod_u;
  logic signed [ACC_W-1:0] g2;
  logic [GRAD_W-1:0]       grad_sat;
  logic [T_W-1:0]          tsum;
  logic [VAR_W-1:0]        sum_add;
  logic                    load2, adv2, put;

  // Stage 2: squares and the saturated doubled gradient
  always_comb begin
    prod_l = s1_dl_i * s1_dl_i;
    prod_u = s1_du_i * s1_du_i;
    g2     = ACC_W'(s1_acc_i) + ACC_W'(s1_acc_i);
    if (g2 > GRAD_HI) begin
      grad_sat = GRAD_W'(GRAD_HI);
    end else if (g2 < GRAD_LO) begin
      grad_sat = GRAD_W'(GRAD_LO);
    end else begin
      grad_sat = GRAD_W'(g2);
    end
  end

  // Items without a result pass stage 2 without waiting on the output
  assign adv2       = s2_valid_q && (!s2_tag_q.res || !out_valid_q || out_ready_i);
  assign s2_ready_o = !s2_valid_q || adv2;
  assign load2      = s1_valid_i && s2_ready_o;
  assign s2_valid_d = load2 || (s2_valid_q && !adv2);
  assign put        = adv2 && s2_tag_q.res;

  // Stage 3: saturating accumulate, result register
  always_comb begin
    tsum    = T_W'(sum_q) + T_W'(sql_q) + T_W'(squ_q);
    sum_add = (tsum > T_W'(VAR_MAX)) ? VAR_MAX : VAR_W'(tsum);
    sum_d   = sum_q;
    if (restart_i) begin
      sum_d = '0;
    end else if (adv2) begin
      sum_d = s2_tag_q.last ? '0 : sum_add;
    end
    out_valid_d = put || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      sum_q       <= '0;
    end else begin
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
      sum_q       <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load2) begin
      s2_tag_q  <= s1_tag_i;
      sql_q     <= SQ_W'(unsigned'(prod_l));
      squ_q     <= SQ_W'(unsigned'(prod_u));
      s2_grad_q <= grad_sat;
    end
    if (put) begin
      out_grad_q  <= s2_grad_q;
      out_row_q   <= s2_tag_q.row;
      out_col_q   <= s2_tag_q.col;
      out_last_q  <= s2_tag_q.last;
      out_total_q <= s2_tag_q.last ? sum_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_grad_o  = out_grad_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_total_o = out_total_q;
  assign out_last_o  = out_last_q;

endmodule

// File: src/squared_variation_and_gradient_unit.sv
// Channel   Dir  Handshake              Content
// s_axis    in   tvalid/tready          tuser: operation; tdata: pixel
// m_axis    out  tvalid/tready/tlast    tdata: gradient, row, col, total; tlast: last
// apb       in   psel/penable/pready    0x0 image_width, 0x4 image_height
//
// One item per cycle sustained while m_axis_tready holds. A taken item passes
// stage 1 and stage 2 before its result sits in the output register.
// Line store: one memory, one write and one read port; each pixel writes its own
// column, every item prefetches the column two ahead, so no read waits on another.
// Reset clears counters, pipeline valids and the running sum; the line store is
// not cleared and needs no clearing pass.
// m_axis_tready low backs the pipeline up stage by stage; s_axis_tready drops
// only when all three stages hold items and the stage-2 item waits on the output.
`timescale 1ns / 1ps

module squared_variation_and_gradient_unit import svg_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int unsigned PIXEL_BITS = DEF_PIXEL_BITS,
  localparam int unsigned IN_DATA_W = ((PIXEL_BITS + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input items
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // pixel
  input  logic                  s_axis_tuser,   // operation
  // result items
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // gradient, grad_row, grad_col, total_variation
  output logic                  m_axis_tlast,   // last
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned DW = PIXEL_BITS + 1;
  localparam int unsigned AW = PIXEL_BITS + 3;
  localparam int unsigned EW = 2 * PIXEL_BITS;

  // Configuration registers
  logic [CFG_W-1:0] width_q, width_d, height_q, height_d;
  logic             cfg_we;
  reg_e             cfg_sel;
  logic [CW-1:0]    wlast;
  logic [RW-1:0]    hlast;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_sel = reg_e'(paddr[2]);

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we) begin
      unique case (cfg_sel)
        REG_WIDTH:  width_d  = pwdata[CFG_W-1:0];
        REG_HEIGHT: height_d = pwdata[CFG_W-1:0];
        default:    width_d  = width_q;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_WIDTH:  prdata = APB_DATA_W'(width_q);
      REG_HEIGHT: prdata = APB_DATA_W'(height_q);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RESET_DIM;
      height_q <= RESET_DIM;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // Last column / row index of the effective image
  assign wlast = CW'(eff_dim(width_q, MAX_WIDTH) - 1);
  assign hlast = RW'(eff_dim(height_q, MAX_HEIGHT) - 1);

  // Line store and front end
  logic                 mem_we, mem_re;
  logic [CW-1:0]        mem_waddr, mem_raddr;
  logic [EW-1:0]        mem_wdata, mem_rdata;
  logic                 s1_valid, s2_ready;
  svg_tag_t             s1_tag;
  logic signed [DW-1:0] s1_dl, s1_du;
  logic signed [AW-1:0] s1_acc;

  svg_line_mem #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (EW)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  svg_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (cfg_we),
    .wlast_i     (wlast),
    .hlast_i     (hlast),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (op_e'(s_axis_tuser)),
    .in_pixel_i  (s_axis_tdata[PIXEL_BITS-1:0]),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .s1_valid_o  (s1_valid),
    .s1_tag_o    (s1_tag),
    .s1_dl_o     (s1_dl),
    .s1_du_o     (s1_du),
    .s1_acc_o    (s1_acc),
    .s2_ready_i  (s2_ready)
  );

  // Squares, gradient saturation, running sum and result register
  logic [GRAD_W-1:0]  out_grad;
  logic [COORD_W-1:0] out_row, out_col;
  logic [VAR_W-1:0]   out_total;

  svg_accum #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (cfg_we),
    .s1_valid_i  (s1_valid),
    .s1_tag_i    (s1_tag),
    .s1_dl_i     (s1_dl),
    .s1_du_i     (s1_du),
    .s1_acc_i    (s1_acc),
    .s2_ready_o  (s2_ready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_grad_o  (out_grad),
    .out_row_o   (out_row),
    .out_col_o   (out_col),
    .out_total_o (out_total),
    .out_last_o  (m_axis_tlast)
  );

  always_comb begin
    m_axis_tdata                           = '0;
    m_axis_tdata[GRAD_LSB +: GRAD_W]       = out_grad;
    m_axis_tdata[ROW_LSB +: COORD_W]       = out_row;
    m_axis_tdata[COL_LSB +: COORD_W]       = out_col;
    m_axis_tdata[TOT_LSB +: VAR_W]         = out_total;
  end

endmodule

// File: src/svg_checker.sv
`timescale 1ns / 1ps

module svg_checker import svg_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // the total only shows on the final gradient of an image
  a_total_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[TOT_LSB +: VAR_W] == '0)
    else $error("total on a non-final result");

  // gradient is doubled, so it is even unless clipped at the top
  a_grad_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      !m_axis_tdata[GRAD_LSB] ||
      (m_axis_tdata[GRAD_LSB +: GRAD_W] == GRAD_W'(GRAD_HI)))
    else $error("odd gradient below saturation");

  // no result right out of reset
  a_quiet_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid out of reset");

endmodule

bind squared_variation_and_gradient_unit svg_checker u_svg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
